// File: sv/shfp_pkg.sv
package shfp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_GOT_FIRST,
        PH_AWAIT_CMD,
        PH_AWAIT_LEN,
        PH_PAYLOAD,
        PH_CHECK,
        PH_EMIT
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SUM_ERR  = 3'd1,
        ST_HDR1_ERR = 3'd2,
        ST_HDR2_ERR = 3'd3,
        ST_LEN_ERR  = 3'd4
    } t_status;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'h55;

endpackage

// File: sv/sync_header_frame_parser.sv
// channel   valid     ready     payload
// input     i_valid   o_ready   i_rx_byte
// output    o_valid   i_ready   o_frame_status, o_command_code, o_payload_length,
//                               o_byte_index, o_payload_byte, o_computed_sum,
//                               o_last_of_frame
//
// one cycle per received byte; the payload of a frame sits in a one-port sram
// a good checksum byte with nonzero length starts a readout (sram read register, then
// one result per cycle while i_ready is high); input is held off meanwhile
// synchronous active-low reset returns the parser to idle; the payload sram
// is not cleared, only entries written in the current frame are read back
// a byte is taken only when the output register is free or being emptied
module sync_header_frame_parser #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_frame_status,
    output logic [7:0] o_command_code,
    output logic [5:0] o_payload_length,
    output logic [4:0] o_byte_index,
    output logic [7:0] o_payload_byte,
    output logic [7:0] o_computed_sum,
    output logic       o_last_of_frame
);

    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [7:0] MAX_B = 8'(MAX_PAYLOAD);

    shfp_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_cmd, n_cmd;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic [LEN_W-1:0] r_k, n_k;
    logic [LEN_W-1:0] r_rd_k;
    logic             r_pend, n_pend;
    logic [7:0]       r_rd_data;

    logic [7:0] r_mem [MAX_PAYLOAD];

    logic             r_o_valid, n_o_valid;
    shfp_pkg::t_status r_o_status, n_o_status;
    logic [7:0]       r_o_cmd, n_o_cmd;
    logic [5:0]       r_o_len, n_o_len;
    logic [4:0]       r_o_idx, n_o_idx;
    logic [7:0]       r_o_data, n_o_data;
    logic [7:0]       r_o_sum, n_o_sum;
    logic             r_o_last, n_o_last;

    logic in_acc;
    logic slot_free;
    logic out_load;
    logic rd_issue;
    logic wr_en;
    logic burst_last;
    logic sum_ok;

    assign slot_free  = !r_o_valid || i_ready;
    assign o_ready    = (r_phase != shfp_pkg::PH_EMIT) && slot_free;
    assign in_acc     = i_valid && o_ready;
    assign sum_ok     = (i_rx_byte == r_sum);
    assign out_load   = (r_phase == shfp_pkg::PH_EMIT) && r_pend && slot_free;
    assign rd_issue   = (r_phase == shfp_pkg::PH_EMIT) && (r_k < r_len)
                        && (!r_pend || out_load);
    assign burst_last = (r_rd_k + LEN_W'(1)) == r_len;
    assign wr_en      = in_acc && (r_phase == shfp_pkg::PH_PAYLOAD);

    // next state
    always_comb begin
        n_phase = r_phase;
        if (in_acc) begin
            unique case (r_phase)
                shfp_pkg::PH_IDLE: begin
                    if (i_rx_byte == shfp_pkg::HDR_FIRST) n_phase = shfp_pkg::PH_GOT_FIRST;
                end
                shfp_pkg::PH_GOT_FIRST: begin
                    n_phase = (i_rx_byte == shfp_pkg::HDR_SECOND) ?
                              shfp_pkg::PH_AWAIT_CMD : shfp_pkg::PH_IDLE;
                end
                shfp_pkg::PH_AWAIT_CMD: begin
                    n_phase = shfp_pkg::PH_AWAIT_LEN;
                end
                shfp_pkg::PH_AWAIT_LEN: begin
                    if (i_rx_byte == 8'd0)      n_phase = shfp_pkg::PH_CHECK;
                    else if (i_rx_byte <= MAX_B) n_phase = shfp_pkg::PH_PAYLOAD;
                    else                         n_phase = shfp_pkg::PH_IDLE;
                end
                shfp_pkg::PH_PAYLOAD: begin
                    if ((r_cnt + LEN_W'(1)) == r_len) n_phase = shfp_pkg::PH_CHECK;
                end
                shfp_pkg::PH_CHECK: begin
                    n_phase = (sum_ok && r_len != '0) ? shfp_pkg::PH_EMIT
                                                      : shfp_pkg::PH_IDLE;
                end
                default: begin
                    n_phase = shfp_pkg::PH_IDLE;
                end
            endcase
        end else if (out_load && burst_last) begin
            n_phase = shfp_pkg::PH_IDLE;
        end
    end

    // datapath and result register
    always_comb begin
        n_sum      = r_sum;
        n_cmd      = r_cmd;
        n_len      = r_len;
        n_cnt      = r_cnt;
        n_k        = r_k;
        n_pend     = r_pend;
        n_o_valid  = r_o_valid && !i_ready;
        n_o_status = r_o_status;
        n_o_cmd    = r_o_cmd;
        n_o_len    = r_o_len;
        n_o_idx    = r_o_idx;
        n_o_data   = r_o_data;
        n_o_sum    = r_o_sum;
        n_o_last   = r_o_last;

        if (in_acc) begin
            // error and empty-frame results share these defaults
            n_o_cmd  = 8'd0;
            n_o_len  = 6'd0;
            n_o_idx  = 5'd0;
            n_o_data = 8'd0;
            n_o_sum  = r_sum;
            n_o_last = 1'b1;
            unique case (r_phase)
                shfp_pkg::PH_IDLE: begin
                    if (i_rx_byte == shfp_pkg::HDR_FIRST) begin
                        n_sum = r_sum + i_rx_byte;
                    end else begin
                        n_o_valid  = 1'b1;
                        n_o_status = shfp_pkg::ST_HDR1_ERR;
                        n_sum      = 8'd0;
                    end
                end
                shfp_pkg::PH_GOT_FIRST: begin
                    if (i_rx_byte == shfp_pkg::HDR_SECOND) begin
                        n_sum = r_sum + i_rx_byte;
                    end else begin
                        n_o_valid  = 1'b1;
                        n_o_status = shfp_pkg::ST_HDR2_ERR;
                        n_sum      = 8'd0;
                    end
                end
                shfp_pkg::PH_AWAIT_CMD: begin
                    n_sum = r_sum + i_rx_byte;
                    n_cmd = i_rx_byte;
                    n_cnt = '0;
                end
                shfp_pkg::PH_AWAIT_LEN: begin
                    if (i_rx_byte == 8'd0) begin
                        n_len = '0;
                    end else if (i_rx_byte <= MAX_B) begin
                        n_sum = r_sum + i_rx_byte;
                        n_len = LEN_W'(i_rx_byte);
                    end else begin
                        n_o_valid  = 1'b1;
                        n_o_status = shfp_pkg::ST_LEN_ERR;
                        n_o_cmd    = r_cmd;
                        n_sum      = 8'd0;
                    end
                end
                shfp_pkg::PH_PAYLOAD: begin
                    n_sum = r_sum + i_rx_byte;
                    n_cnt = r_cnt + LEN_W'(1);
                end
                shfp_pkg::PH_CHECK: begin
                    n_o_cmd = r_cmd;
                    if (!sum_ok) begin
                        n_o_valid  = 1'b1;
                        n_o_status = shfp_pkg::ST_SUM_ERR;
                        n_o_len    = 6'(r_len);
                        n_sum      = 8'd0;
                    end else if (r_len == '0) begin
                        n_o_valid  = 1'b1;
                        n_o_status = shfp_pkg::ST_OK;
                        n_sum      = 8'd0;
                    end else begin
                        // sum is held for the readout burst
                        n_k    = '0;
                        n_pend = 1'b0;
                    end
                end
                default: begin
                    n_sum = 8'd0;
                end
            endcase
        end

        if (out_load) begin
            n_o_valid  = 1'b1;
            n_o_status = shfp_pkg::ST_OK;
            n_o_cmd    = r_cmd;
            n_o_len    = 6'(r_len);
            n_o_idx    = 5'(r_rd_k);
            n_o_data   = r_rd_data;
            n_o_sum    = r_sum;
            n_o_last   = burst_last;
            n_pend     = 1'b0;
            if (burst_last) n_sum = 8'd0;
        end
        if (rd_issue) begin
            n_k    = r_k + LEN_W'(1);
            n_pend = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= shfp_pkg::PH_IDLE;
            r_sum     <= 8'd0;
            r_cmd     <= 8'd0;
            r_len     <= '0;
            r_cnt     <= '0;
            r_k       <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_sum     <= n_sum;
            r_cmd     <= n_cmd;
            r_len     <= n_len;
            r_cnt     <= n_cnt;
            r_k       <= n_k;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_status <= n_o_status;
        r_o_cmd    <= n_o_cmd;
        r_o_len    <= n_o_len;
        r_o_idx    <= n_o_idx;
        r_o_data   <= n_o_data;
        r_o_sum    <= n_o_sum;
        r_o_last   <= n_o_last;
    end

    // payload sram: write during payload beats, read during the readout burst
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_cnt[ADDR_W-1:0]] <= i_rx_byte;
        end
        if (rd_issue) begin
            r_rd_data <= r_mem[r_k[ADDR_W-1:0]];
            r_rd_k    <= r_k;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_frame_status   = r_o_status;
    assign o_command_code   = r_o_cmd;
    assign o_payload_length = r_o_len;
    assign o_byte_index     = r_o_idx;
    assign o_payload_byte   = r_o_data;
    assign o_computed_sum   = r_o_sum;
    assign o_last_of_frame  = r_o_last;

    a_no_input_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == shfp_pkg::PH_EMIT) |-> !o_ready)
        else $error("input taken during readout burst");

    a_pend_only_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_phase == shfp_pkg::PH_EMIT))
        else $error("sram read pending outside readout burst");

    a_read_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == shfp_pkg::PH_EMIT) |-> (r_k <= r_len))
        else $error("readout index past frame length");

    a_burst_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && burst_last) |=> (r_phase == shfp_pkg::PH_IDLE && r_sum == 8'd0))
        else $error("parser not idle after last payload beat");

    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc || out_load) |-> slot_free)
        else $error("result register overwritten while full");

endmodule
